// File: sv/msfg_pkg.sv
// shared types, constants and helper functions for the m-sequence frame generator
`default_nettype none

package msfg_pkg;

    // widths fixed by the register map and the sample format
    localparam int LFSR_MAX     = 16;
    localparam int DEG_W        = 5;
    localparam int SPC_W        = 8;
    localparam int POS_W        = 16;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_TDATA_W   = 8;

    // sample levels for the two chip values
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE  = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_ZERO = 16'sh8000;

    // register reset values
    localparam logic [DEG_W-1:0]      DEGREE_RST = 5'd8;
    localparam logic [LFSR_MAX-1:0]   TAPS_RST   = 16'd135;
    localparam logic [SPC_W-1:0]      SPC_RST    = 8'd4;
    localparam logic [POS_W-1:0]      LEAD_RST   = 16'd0;
    localparam logic [POS_W-1:0]      FLEN_RST   = 16'd2048;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE = 3'd0,
        REG_TAPS   = 3'd1,
        REG_SPC    = 3'd2,
        REG_LEAD   = 3'd3,
        REG_FLEN   = 3'd4
    } reg_idx_t;

    // configuration as seen by the core
    typedef struct packed {
        logic [DEG_W-1:0]      degree;
        logic [LFSR_MAX-1:0]   taps;
        logic [SPC_W-1:0]      samples_per_chip;
        logic [POS_W-1:0]      lead_zeros;
        logic [POS_W-1:0]      frame_length;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       code_active;
        logic                       last;
    } result_t;

    // degree clamped to the supported range
    function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] k;
        k = d;
        if (k < DEG_W'(2))
        begin
            k = DEG_W'(2);
        end
        if (k > DEG_W'(LFSR_MAX))
        begin
            k = DEG_W'(LFSR_MAX);
        end
        return k;
    endfunction

    // low k bits set, also the chip count of the code
    function automatic logic [LFSR_MAX-1:0] low_mask(input logic [DEG_W-1:0] k);
        logic [LFSR_MAX-1:0] m;
        for (int i = 0; i < LFSR_MAX; i++)
        begin
            m[i] = (DEG_W'(i) < k);
        end
        return m;
    endfunction

    // one galois lfsr step of length k
    function automatic logic [LFSR_MAX-1:0] lfsr_step(
        input logic [LFSR_MAX-1:0] s,
        input logic [LFSR_MAX-1:0] t,
        input logic [DEG_W-1:0]    k
    );
        logic [DEG_W-1:0]      km1;
        logic                  top;
        logic [LFSR_MAX-1:0]   m;
        logic [LFSR_MAX-1:0]   n;
        km1 = k - DEG_W'(1);
        top = s[km1[$clog2(LFSR_MAX)-1:0]];
        m   = low_mask(k);
        n   = ({s[LFSR_MAX-2:0], 1'b0} ^ (t & {LFSR_MAX{top}})) & m;
        return n;
    endfunction

endpackage

`default_nettype wire

// File: sv/msfg_core.sv
// frame state and per-sample step of the m-sequence frame generator
`default_nettype none

module msfg_core
    import msfg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    step,
    input  wire logic    restart,
    output result_t      result
);

    logic [LFSR_MAX-1:0]   shift_reg, shift_next;
    logic [LFSR_MAX-1:0]   chips_reg, chips_next;
    logic [SPC_W-1:0]      sic_reg, sic_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    logic [LFSR_MAX-1:0]   cur_shift;
    logic [LFSR_MAX-1:0]   cur_chips;
    logic [SPC_W-1:0]      cur_sic;
    logic [POS_W-1:0]      cur_pos;
    logic [DEG_W-1:0]      k;
    logic [LFSR_MAX-1:0]   chip_count;
    logic [SPC_W-1:0]      spc;
    logic [POS_W-1:0]      flen;
    logic [SPC_W:0]        sic_inc;
    logic                  active;
    logic                  chip_end;
    logic                  last;

    // state seen by this sample, restart seeds a fresh frame
    always_comb
    begin
        if (restart)
        begin
            cur_shift = LFSR_MAX'(1);
            cur_chips = '0;
            cur_sic   = '0;
            cur_pos   = '0;
        end
        else
        begin
            cur_shift = shift_reg;
            cur_chips = chips_reg;
            cur_sic   = sic_reg;
            cur_pos   = pos_reg;
        end
    end

    // effective settings
    always_comb
    begin
        k          = eff_degree(cfg.degree);
        chip_count = low_mask(k);
        spc        = (cfg.samples_per_chip == '0) ? SPC_W'(1) : cfg.samples_per_chip;
        flen       = (cfg.frame_length == '0) ? POS_W'(1) : cfg.frame_length;
    end

    // sample, chip and frame bookkeeping
    always_comb
    begin
        active   = (cur_pos >= cfg.lead_zeros) && (cur_chips < chip_count);
        sic_inc  = {1'b0, cur_sic} + (SPC_W+1)'(1);
        chip_end = active && (sic_inc >= {1'b0, spc});
        last     = (cur_pos >= (flen - POS_W'(1)));

        result.code_active = active;
        result.last        = last;
        if (!active)
        begin
            result.sample = '0;
        end
        else if (cur_shift[0])
        begin
            result.sample = SAMPLE_ONE;
        end
        else
        begin
            result.sample = SAMPLE_ZERO;
        end

        if (last)
        begin
            shift_next = LFSR_MAX'(1);
            chips_next = '0;
            sic_next   = '0;
            pos_next   = '0;
        end
        else
        begin
            pos_next = cur_pos + POS_W'(1);
            if (chip_end)
            begin
                shift_next = lfsr_step(cur_shift, cfg.taps, k);
                chips_next = cur_chips + LFSR_MAX'(1);
                sic_next   = '0;
            end
            else
            begin
                shift_next = cur_shift;
                chips_next = cur_chips;
                sic_next   = active ? sic_inc[SPC_W-1:0] : cur_sic;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= LFSR_MAX'(1);
            chips_reg <= '0;
            sic_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            shift_reg <= shift_next;
            chips_reg <= chips_next;
            sic_reg   <= sic_next;
            pos_reg   <= pos_next;
        end
    end

    // a finished frame leaves the counters at the start of the next one
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (pos_reg == '0 && chips_reg == '0 && shift_reg == LFSR_MAX'(1)))
        else $error("frame state not reseeded after last sample");

    // a code sample either clears the sample-in-chip counter or moves it on by one
    a_sic_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step && active) |=> (sic_reg == '0 || sic_reg == $past(sic_inc[SPC_W-1:0])))
        else $error("sample-in-chip counter out of step");

endmodule

`default_nettype wire

// File: sv/msequence_chip_frame_generator_top.sv
// top level of the m-sequence frame generator: ports, registers, output buffering
//
// Generates one framed m-sequence sample for each request on the s_axis side.
// s_tdata[0] is restart: 1 starts a new frame with the lfsr seeded to one.
// Each frame holds lead_zeros zero samples, then 2^degree-1 chips of a galois
// lfsr, each repeated samples_per_chip times as +32767 / -32768, then zero
// padding up to frame_length samples; m_tlast marks the frame's last sample
// and the following request starts a new frame on its own.
// Results leave on the m_axis side: m_tdata is the sample, m_tuser is the
// code_active flag. Each result is registered, and a new request is taken every
// cycle while s_tready is high; the lfsr step and counter updates all sit in one
// pass of logic between the frame state and the output register. When the
// receiver stalls, a second output register takes one more result, after which
// s_tready drops until the receiver drains it. Registers are written through
// cfg_valid/cfg_index/cfg_data (cfg_ready is always high); the user writes them
// only while the block is idle, which the block does not enforce. Reset restores
// the register defaults (degree 8, taps 135, four samples per chip, no lead
// zeros, 2048 per frame), empties the output registers and seeds the frame state.
`default_nettype none

module msequence_chip_frame_generator_top
    import msfg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // request side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
    // result side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [SAMPLE_W-1:0]        m_tdata,   // [15:0] sample
    output logic                       m_tuser,   // [0] code_active
    output logic                       m_tlast
);

    cfg_t    cfg_reg;
    result_t new_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    take;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degree           <= DEGREE_RST;
            cfg_reg.taps             <= TAPS_RST;
            cfg_reg.samples_per_chip <= SPC_RST;
            cfg_reg.lead_zeros       <= LEAD_RST;
            cfg_reg.frame_length     <= FLEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DEGREE: cfg_reg.degree           <= cfg_data[DEG_W-1:0];
                REG_TAPS:   cfg_reg.taps             <= cfg_data[LFSR_MAX-1:0];
                REG_SPC:    cfg_reg.samples_per_chip <= cfg_data[SPC_W-1:0];
                REG_LEAD:   cfg_reg.lead_zeros       <= cfg_data[POS_W-1:0];
                REG_FLEN:   cfg_reg.frame_length     <= cfg_data[POS_W-1:0];
                default:    ;
            endcase
        end
    end

    // handshakes
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;

    // sample generation
    msfg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step    (accept),
        .restart (s_tdata[0]),
        .result  (new_result)
    );

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= new_result;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= new_result;
            end
            else
            begin
                out_reg <= new_result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.sample;
    assign m_tuser  = out_reg.code_active;
    assign m_tlast  = out_reg.last;

    // the skid entry only fills behind a full output register
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // code samples carry one of the two chip levels
    a_code_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == SAMPLE_ONE || m_tdata == SAMPLE_ZERO))
        else $error("code sample not at a chip level");

    // outside the code the sample is zero
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("non-zero sample outside the code");

    // a held result is not overwritten while the receiver stalls
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("buffered result dropped during stall");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the m-sequence frame generator: corners, random frames, stalls
`default_nettype none

module tb_top;
    import msfg_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DEGREE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;   // [0] restart, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;          // [15:0] sample
    logic                  m_tuser;          // [0] code_active
    logic                  m_tlast;

    // register copies held by the predictor
    logic [DEG_W-1:0]      cfg_degree = DEGREE_RST;
    logic [LFSR_MAX-1:0]   cfg_taps   = TAPS_RST;
    logic [SPC_W-1:0]      cfg_spc    = SPC_RST;
    logic [POS_W-1:0]      cfg_lead   = LEAD_RST;
    logic [POS_W-1:0]      cfg_flen   = FLEN_RST;

    // frame state held by the predictor
    logic [LFSR_MAX-1:0]   lfsr_bits   = 16'd1;
    int unsigned           chips_sent  = 0;
    int unsigned           chip_repeat = 0;
    int unsigned           frame_pos   = 0;

    result_t expected_samples[$];

    int sender_idle_pct   = 25;
    int receiver_idle_pct = 70;
    int hold_requests     = 0;
    int holds_served      = 0;
    int hold_left         = 0;

    int mismatch_count     = 0;
    int requests_sent      = 0;
    int samples_checked    = 0;
    int frame_ends         = 0;
    int code_samples       = 0;
    int input_stall_cycles = 0;
    int settings_loaded    = 0;

    msequence_chip_frame_generator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // seeded register, counters back to the frame start
    function automatic void seed_frame();
        lfsr_bits   = 16'd1;
        chips_sent  = 0;
        chip_repeat = 0;
        frame_pos   = 0;
    endfunction

    // sample produced for one request, advancing the frame state
    function automatic result_t next_chip_sample(input logic restart);
        int unsigned           k;
        int unsigned           chip_count;
        int unsigned           spc;
        int unsigned           flen;
        int unsigned           pos;
        logic [LFSR_MAX-1:0]   mask;
        logic                  top;
        result_t               r;
        k = (cfg_degree < 2) ? 2 : ((cfg_degree > LFSR_MAX) ? LFSR_MAX : cfg_degree);
        chip_count = (32'd1 << k) - 1;
        spc  = (cfg_spc == 0) ? 1 : cfg_spc;
        flen = (cfg_flen == 0) ? 1 : cfg_flen;
        if (restart)
        begin
            seed_frame();
        end
        pos = frame_pos;
        r = '0;
        // code region: chip value held for spc samples, then one lfsr step
        if (pos >= cfg_lead && chips_sent < chip_count)
        begin
            r.code_active = 1'b1;
            r.sample = lfsr_bits[0] ? SAMPLE_ONE : SAMPLE_ZERO;
            chip_repeat++;
            if (chip_repeat >= spc)
            begin
                chip_repeat = 0;
                chips_sent++;
                mask = LFSR_MAX'((32'd1 << k) - 1);
                top  = lfsr_bits[k-1];
                lfsr_bits = ({lfsr_bits[LFSR_MAX-2:0], 1'b0} ^ (top ? cfg_taps : '0)) & mask;
            end
        end
        // frame end, next request starts afresh
        r.last = (pos >= flen - 1);
        if (r.last)
        begin
            seed_frame();
        end
        else
        begin
            frame_pos = pos + 1;
        end
        return r;
    endfunction

    function automatic void apply_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_DEGREE: cfg_degree = value[DEG_W-1:0];
            REG_TAPS:   cfg_taps   = value[LFSR_MAX-1:0];
            REG_SPC:    cfg_spc    = value[SPC_W-1:0];
            REG_LEAD:   cfg_lead   = value[POS_W-1:0];
            REG_FLEN:   cfg_flen   = value[POS_W-1:0];
            default:    ;
        endcase
    endfunction

    function automatic void report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%s", what);
        end
    endfunction

    // one register write; cfg_valid is left high for a following write
    task automatic write_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_register(idx, value);
    endtask

    // full register set, only while the block is idle
    task automatic load_settings(
        input logic [CFG_DATA_W-1:0] degree,
        input logic [CFG_DATA_W-1:0] taps,
        input logic [CFG_DATA_W-1:0] spc,
        input logic [CFG_DATA_W-1:0] lead,
        input logic [CFG_DATA_W-1:0] flen
    );
        write_register(REG_DEGREE, degree);
        write_register(REG_TAPS, taps);
        write_register(REG_SPC, spc);
        write_register(REG_LEAD, lead);
        write_register(REG_FLEN, flen);
        cfg_valid <= 1'b0;
        settings_loaded++;
        @(posedge clk);
    endtask

    // one request with optional idle gap ahead of it; s_tvalid stays high afterwards
    task automatic send_item(input logic restart);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_samples.insert(expected_samples.size(), next_chip_sample(restart));
        requests_sent++;
    endtask

    // stop requesting and wait for every expected sample
    task automatic end_of_burst();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_samples.size() != 0);
    endtask

    task automatic test_reset_state();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        end_of_burst();
    endtask

    task automatic test_corner_settings();
        // degree below range, zero samples per chip, one lead zero, short frame
        load_settings(16'd0, 16'h0003, 16'd0, 16'd1, 16'd5);
        send_item(1'b1);
        repeat (5) send_item(1'b0);
        end_of_burst();
        // zero frame length: every sample closes a frame; taps above degree ignored
        load_settings(16'd5, 16'hFFFF, 16'd1, 16'd0, 16'd0);
        send_item(1'b1);
        send_item(1'b0);
        end_of_burst();
        // lead zeros fill the frame, degree above range, top samples per chip
        load_settings(16'd31, 16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        end_of_burst();
        // code far longer than the longest frame
        load_settings(16'd16, 16'hFFFF, 16'd255, 16'd0, 16'hFFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        end_of_burst();
        // no constant term in the taps: sequence collapses to zero chips
        load_settings(16'd3, 16'h0000, 16'd1, 16'd0, 16'd10);
        send_item(1'b1);
        repeat (5) send_item(1'b0);
        end_of_burst();
    endtask

    // mostly short codes in short frames, now and then extreme settings
    task automatic load_random_settings();
        logic [CFG_DATA_W-1:0] degree;
        logic [CFG_DATA_W-1:0] taps;
        logic [CFG_DATA_W-1:0] spc;
        logic [CFG_DATA_W-1:0] lead;
        logic [CFG_DATA_W-1:0] flen;
        case ($urandom_range(9))
            0:       degree = CFG_DATA_W'($urandom_range(31));
            1:       degree = 16'd16;
            default: degree = CFG_DATA_W'($urandom_range(2, 5));
        endcase
        taps = CFG_DATA_W'($urandom_range(16'hFFFF));
        if ($urandom_range(3) != 0)
        begin
            taps[0] = 1'b1;
        end
        case ($urandom_range(9))
            0:       spc = CFG_DATA_W'($urandom_range(255));
            1:       spc = 16'd0;
            default: spc = CFG_DATA_W'($urandom_range(1, 3));
        endcase
        case ($urandom_range(9))
            0:       lead = CFG_DATA_W'($urandom_range(16'hFFFF));
            1:       lead = CFG_DATA_W'($urandom_range(40, 200));
            default: lead = CFG_DATA_W'($urandom_range(0, 6));
        endcase
        case ($urandom_range(9))
            0:       flen = CFG_DATA_W'($urandom_range(0, 3));
            1:       flen = CFG_DATA_W'($urandom_range(16'hFFFF));
            default: flen = CFG_DATA_W'($urandom_range(8, 120));
        endcase
        load_settings(degree, taps, spc, lead, flen);
    endtask

    // whole frames with random content, some bursts of restart noise
    task automatic test_random_frames(input int phases, input int items);
        int restart_pct;
        for (int p = 0; p < phases; p++)
        begin
            load_random_settings();
            restart_pct = ($urandom_range(3) == 0) ? 50 : 3;
            // sometimes carry the old frame across the new settings
            send_item($urandom_range(3) != 0);
            for (int i = 1; i < items; i++)
            begin
                send_item($urandom_range(99) < restart_pct);
            end
            end_of_burst();
        end
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_output_backpressure();
        load_settings(16'd4, 16'h0009, 16'd2, 16'd3, 16'd50);
        hold_requests <= hold_requests + 1;
        send_item(1'b1);
        repeat (59) send_item(1'b0);
        end_of_burst();
    endtask

    // receiver: random stalls, long hold-off on demand
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // result check against the oldest expected sample
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (s_tvalid && !s_tready)
        begin
            input_stall_cycles++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected sample %0d code %0b last %0b",
                    $signed(m_tdata), m_tuser, m_tlast));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata !== want.sample || m_tuser !== want.code_active
                    || m_tlast !== want.last)
                begin
                    report_mismatch($sformatf(
                        "sample %0d: got %0d/%0b/%0b, want %0d/%0b/%0b (sample/code/last)",
                        samples_checked, $signed(m_tdata), m_tuser, m_tlast,
                        want.sample, want.code_active, want.last));
                end
                samples_checked++;
                if (want.last)
                begin
                    frame_ends++;
                end
                if (want.code_active)
                begin
                    code_samples++;
                end
            end
        end
    end

    // watchdog on cycles without any request, result or register write
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout after %0d quiet cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 25;
        receiver_idle_pct = 70;
        test_reset_state();
        test_corner_settings();
        test_random_frames(5, 65);

        sender_idle_pct   = 70;
        receiver_idle_pct = 25;
        test_random_frames(5, 65);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_frames(5, 65);
        test_output_backpressure();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected samples never arrived",
                expected_samples.size()));
        end

        $display("covered %0d requests over %0d register settings: %0d samples checked",
            requests_sent, settings_loaded, samples_checked);
        $display("%0d frame ends, %0d code samples, input held off for %0d cycles",
            frame_ends, code_samples, input_stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
